// ===== hw/rtl/phr_pkg.sv =====
package phr_pkg;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_REDUCED = 2'd0,
      STATUS_SPECIAL = 2'd1,
      STATUS_TINY    = 2'd2
   } status_type;

   localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
   localparam logic [11:0] EXP_BIAS     = 12'h3fe;
   localparam logic [62:0] TINY_LIMIT   = 63'h3e57137449123ef6;
   localparam int          ROM_WORDS    = 19;
   localparam int          ROM_LAST     = ROM_WORDS - 1;

   // 1216-bit 1/(2*pi), most significant word first
   localparam logic [63:0] INV2PI [ROM_WORDS] = '{
      64'h28be60db9391054a, 64'h7f09d5f47d4d3770, 64'h36d8a5664f10e410,
      64'h7f9458eaf7aef158, 64'h6dc91b8e909374b8, 64'h01924bba82746487,
      64'h3f877ac72c4a69cf, 64'hba208d7d4baed121, 64'h3a671c09ad17df90,
      64'h4e64758e60d4ce7d, 64'h272117e2ef7e4a0e, 64'hc7fe25fff7816603,
      64'hfbcbc462d6829b47, 64'hdb4d9fb3c9f2c26d, 64'hd3d18fd9a797fa8b,
      64'h5d49eeb1faf97c5e, 64'hcf41ce7de294a4ba, 64'h9afed7ec47e35742,
      64'h1580cc11bf1edaea
   };

   // sideband that travels with each operand
   typedef struct packed {
      status_type        status;
      logic              sign;
      logic [6:0]        shift;
      logic signed [5:0] fexp;
   } meta_type;

   // load enables of the product stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } prod_en_type;

endpackage

// ===== hw/rtl/phr_req_if.sv =====
interface phr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] x_bits;

   modport source (output valid, output x_bits, input ready);
   modport sink (input valid, input x_bits, output ready);
endinterface

// ===== hw/rtl/phr_rsp_if.sv =====
interface phr_rsp_if;
   logic                 valid;
   logic                 ready;
   phr_pkg::status_type  status;
   logic                 sign;
   logic [63:0]          frac_hi;
   logic [63:0]          frac_lo;
   logic signed [5:0]    frac_exp;
   logic [8:0]           table_index;
   logic [63:0]          rem_hi;

   modport source (output valid, output status, output sign, output frac_hi,
                   output frac_lo, output frac_exp, output table_index,
                   output rem_hi, input ready);
   modport sink (input valid, input status, input sign, input frac_hi,
                 input frac_lo, input frac_exp, input table_index,
                 input rem_hi, output ready);
endinterface

// ===== hw/rtl/phr_prod.sv =====
// 64 x 256-bit product, keeps bits [319:64]; four register stages
module phr_prod (
   input  logic                      clock,
   input  phr_pkg::prod_en_type      en,
   input  logic [63:0]               m,
   input  logic [3:0][63:0]          words,
   output logic [255:0]              x_out
);
   logic [3:0][3:0][63:0] pp_ff, pp_in;
   logic [3:0][127:0]     prod_ff, prod_in;
   logic [192:0]          hi_ff, hi_in, lo_ff, lo_in;
   logic [255:0]          x_ff, x_in;
   logic [320:0]          sum;

   // stage 2: 32x32 partial products
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pp_in[k][0] = 64'(m[31:0])  * 64'(words[k][31:0]);
         pp_in[k][1] = 64'(m[31:0])  * 64'(words[k][63:32]);
         pp_in[k][2] = 64'(m[63:32]) * 64'(words[k][31:0]);
         pp_in[k][3] = 64'(m[63:32]) * 64'(words[k][63:32]);
      end
   end

   // stage 3: full 128-bit products
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = {pp_ff[k][3], pp_ff[k][0]}
                    + {32'd0, pp_ff[k][1], 32'd0}
                    + {32'd0, pp_ff[k][2], 32'd0};
      end
   end

   // stage 4: pair sums, stage 5: final sum with low word dropped
   // words[3] is the most significant constant word
   assign hi_in = {1'b0, prod_ff[3], 64'd0} + {65'd0, prod_ff[2]};
   assign lo_in = {1'b0, prod_ff[1], 64'd0} + {65'd0, prod_ff[0]};
   assign sum   = {hi_ff, 128'd0} + {128'd0, lo_ff};
   assign x_in  = sum[319:64];

   always_ff @(posedge clock) begin
      if (en.s2) pp_ff <= pp_in;
      if (en.s3) prod_ff <= prod_in;
      if (en.s4) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      if (en.s5) x_ff <= x_in;
   end

   assign x_out = x_ff;
endmodule

// ===== hw/rtl/payne_hanek_reduce_binary64.sv =====
// channel | dir | payload                                         | handshake
// req_ch  | in  | x_bits                                          | valid/ready
// rsp_ch  | out | status sign frac_hi frac_lo frac_exp            | valid/ready
//         |     | table_index rem_hi                              |
// Seven register stages; one operand per cycle sustained while rsp_ch is ready.
// Depth is set by the 64x256 product (partials, sums, 321-bit add) and shift.
// Synchronous reset clears the stage valid bits only.
// Each stage holds while the stage after it is full and stalled; nothing lost.
module payne_hanek_reduce_binary64 #(
   parameter int INDEX_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   phr_req_if.sink     req_ch,
   phr_rsp_if.source   rsp_ch
);
   localparam int NSTG = 7;

   logic [NSTG:1]        v_ff;
   logic [NSTG+1:1]      en;
   phr_pkg::meta_type    meta_ff [1:6];
   phr_pkg::meta_type    meta_in;
   phr_pkg::prod_en_type pen;
   logic [63:0]          m_ff, m_in;
   logic [3:0][63:0]     words_ff, words_in;
   logic [255:0]         x;
   logic [127:0]         f_ff, f_in;
   logic [255:0]         shifted;

   // stage advance: load when empty or when the next stage moves
   always_comb begin
      en[NSTG+1] = rsp_ch.ready;
      for (int k = NSTG; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign req_ch.ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NSTG; k++) begin
            if (en[k]) v_ff[k] <= (k == 1) ? req_ch.valid : v_ff[k-1];
         end
      end
   end

   // stage 1: classify, normalize, pick constant words
   always_comb begin
      logic [10:0]        ebits;
      logic signed [11:0] e;
      logic [3:0]         w;
      logic [4:0]         idx;
      logic [11:0]        tmp;
      ebits   = req_ch.x_bits[62:52];
      e       = $signed({1'b0, ebits}) - $signed(phr_pkg::EXP_BIAS);
      meta_in.sign = req_ch.x_bits[63];
      if (ebits == phr_pkg::EXP_ALL_ONES) begin
         meta_in.status = phr_pkg::STATUS_SPECIAL;
      end else if (req_ch.x_bits[62:0] <= phr_pkg::TINY_LIMIT) begin
         meta_in.status = phr_pkg::STATUS_TINY;
      end else begin
         meta_in.status = phr_pkg::STATUS_REDUCED;
      end
      m_in = {1'b1, req_ch.x_bits[51:0], 11'd0};
      w    = '0;
      tmp  = '0;
      idx  = '0;
      if (e <= 12'sd1) begin
         meta_in.fexp  = e[5:0];
         meta_in.shift = '0;
         words_in = {phr_pkg::INV2PI[0], phr_pkg::INV2PI[1], 64'd0, 64'd0};
      end else begin
         meta_in.fexp = '0;
         if (e >= 12'sd127) begin
            tmp = 12'(e - 12'sd64);
            w   = tmp[9:6];
         end
         tmp = 12'(e) - {2'd0, w, 6'd0};
         meta_in.shift = tmp[6:0];
         for (int k = 0; k < 4; k++) begin
            idx = 5'(w) + 5'(k);
            if (idx > 5'(phr_pkg::ROM_LAST)) idx = 5'(phr_pkg::ROM_LAST);
            words_in[3-k] = phr_pkg::INV2PI[idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         meta_ff[1] <= meta_in;
         m_ff       <= m_in;
         words_ff   <= words_in;
      end
      for (int k = 2; k <= 6; k++) begin
         if (en[k]) meta_ff[k] <= meta_ff[k-1];
      end
   end

   // stages 2 to 5: product
   assign pen = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5]};

   phr_prod u_prod (
      .clock (clock),
      .en    (pen),
      .m     (m_ff),
      .words (words_ff),
      .x_out (x)
   );

   // stage 6: align fraction
   assign shifted = x << meta_ff[5].shift;
   assign f_in    = shifted[255:128];

   always_ff @(posedge clock) begin
      if (en[6]) f_ff <= f_in;
   end

   // stage 7: index split, output register
   phr_pkg::status_type status_ff;
   logic                sign_ff;
   logic [63:0]         fh_ff, fl_ff, rem_ff;
   logic signed [5:0]   fexp_ff;
   logic [8:0]          tidx_ff;
   logic [63:0]         rem_in;
   logic [8:0]          tidx_in;

   always_comb begin
      logic [6:0]  s;
      logic [63:0] full;
      s    = 7'(64 - INDEX_BITS - int'(meta_ff[6].fexp));
      full = f_ff[127:64] >> s;
      if (int'(meta_ff[6].fexp) <= -INDEX_BITS) begin
         tidx_in = '0;
         rem_in  = f_ff[127:64];
      end else begin
         tidx_in = full[8:0];
         rem_in  = f_ff[127:64] & ~({64{1'b1}} << s);
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         status_ff <= meta_ff[6].status;
         sign_ff   <= meta_ff[6].sign;
         if (meta_ff[6].status == phr_pkg::STATUS_REDUCED) begin
            fh_ff   <= f_ff[127:64];
            fl_ff   <= f_ff[63:0];
            fexp_ff <= meta_ff[6].fexp;
            tidx_ff <= tidx_in;
            rem_ff  <= rem_in;
         end else begin
            fh_ff   <= '0;
            fl_ff   <= '0;
            fexp_ff <= '0;
            tidx_ff <= '0;
            rem_ff  <= '0;
         end
      end
   end

   assign rsp_ch.valid       = v_ff[NSTG];
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.sign        = sign_ff;
   assign rsp_ch.frac_hi     = fh_ff;
   assign rsp_ch.frac_lo     = fl_ff;
   assign rsp_ch.frac_exp    = fexp_ff;
   assign rsp_ch.table_index = tidx_ff;
   assign rsp_ch.rem_hi      = rem_ff;
endmodule

// ===== hw/rtl/phr_check.sv =====
module phr_check (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input phr_pkg::status_type rsp_status,
   input logic [63:0]         rsp_frac_hi,
   input logic [63:0]         rsp_frac_lo,
   input logic [8:0]          rsp_table_index,
   input logic [63:0]         rsp_rem_hi
);
   // a held transaction keeps the high word of its fraction
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frac_hi))
      else $error("rsp transaction changed while stalled");

   // pipeline is empty right after reset
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // special and tiny operands carry no fraction
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != phr_pkg::STATUS_REDUCED |->
      rsp_frac_hi == '0 && rsp_frac_lo == '0 && rsp_table_index == '0 &&
      rsp_rem_hi == '0)
      else $error("non-reduced result has payload");

   // remainder never holds bits the fraction lacks
   a_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rem_hi & ~rsp_frac_hi) == '0)
      else $error("remainder not a subset of fraction");
endmodule

bind payne_hanek_reduce_binary64 phr_check u_phr_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_frac_hi     (rsp_ch.frac_hi),
   .rsp_frac_lo     (rsp_ch.frac_lo),
   .rsp_table_index (rsp_ch.table_index),
   .rsp_rem_hi      (rsp_ch.rem_hi)
);
